// ----- hw/rtl/rfab_pkg.sv -----
package rfab_pkg;

   localparam int FbWidthDefault  = 256;
   localparam int FbHeightDefault = 256;
   localparam int MinZoom         = 3;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_FILL    = 2'd1,
      OP_OUTLINE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_ACTIVE_WIDTH  = 3'd0,
      REG_ACTIVE_HEIGHT = 3'd1,
      REG_CAMERA_X      = 3'd2,
      REG_CAMERA_Y      = 3'd3,
      REG_CAMERA_ZOOM   = 3'd4
   } reg_type;

   // rectangle in screen pixels after clipping, end exclusive
   typedef struct packed {
      logic [12:0] x0;
      logic [12:0] y0;
      logic [12:0] x1;
      logic [12:0] y1;
   } rect_type;

   // pixel write request toward the framebuffer
   typedef struct packed {
      logic        clear;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } paint_type;

   // exact floor(v / 255) for v < 65280
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] q;
      logic [16:0] s;
      begin
         s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
         q = s >> 8;
         div255 = q[7:0];
      end
   endfunction

endpackage

// ----- hw/rtl/rfab_xform.sv -----
// screen transform and clip of one fill rectangle, two stages with a register
// after the multiply
module rfab_xform (
   input  logic                clock,
   input  logic                start,
   input  logic signed [17:0]  px,
   input  logic signed [17:0]  py,
   input  logic signed [17:0]  sw,
   input  logic signed [17:0]  sh,
   input  logic                cam_on,
   input  logic signed [15:0]  cam_x,
   input  logic signed [15:0]  cam_y,
   input  logic [15:0]         zoom,
   input  logic [12:0]         act_w,
   input  logic [12:0]         act_h,
   output logic                done,
   output logic                under,
   output rfab_pkg::rect_type  rect
);
   logic signed [18:0] rx_ff, ry_ff;
   logic signed [18:0] rx_in, ry_in;
   logic signed [17:0] rw_ff, rh_ff;
   logic signed [16:0] z_ff;
   logic               v1_ff;
   logic               v2_ff;
   logic               under_ff, under_in;
   rfab_pkg::rect_type rect_ff, rect_in;
   logic signed [36:0] xs, ys, xe, ye;
   logic signed [24:0] fx, fy, cx, cy;
   logic signed [24:0] aw, ah;
   logic [15:0]        zeff;

   always_comb begin
      zeff = (zoom < 16'(rfab_pkg::MinZoom)) ? 16'(rfab_pkg::MinZoom) : zoom;
      if (cam_on) begin
         rx_in = 19'(px) - 19'(cam_x);
         ry_in = 19'(py) - 19'(cam_y);
      end else begin
         rx_in = 19'(px);
         ry_in = 19'(py);
      end
   end

   always_ff @(posedge clock) begin
      v1_ff <= start;
      v2_ff <= v1_ff;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rw_ff <= sw;
      rh_ff <= sh;
      z_ff  <= cam_on ? signed'({1'b0, zeff}) : 17'sd256;
      rect_ff  <= rect_in;
      under_ff <= under_in;
   end

   always_comb begin
      aw = signed'(25'(act_w));
      ah = signed'(25'(act_h));
      xs = 37'(rx_ff) * 37'(z_ff);
      ys = 37'(ry_ff) * 37'(z_ff);
      xe = xs + 37'(rw_ff) * 37'(z_ff);
      ye = ys + 37'(rh_ff) * 37'(z_ff);
      fx = 25'(xs >>> 12);
      fy = 25'(ys >>> 12);
      cx = 25'((xe + 37'sd4095) >>> 12);
      cy = 25'((ye + 37'sd4095) >>> 12);
      // start left of or above the area
      under_in = (fx < 0) || (fy < 0);
      if (fx < 0) fx = '0;
      if (fy < 0) fy = '0;
      if (cx > aw) cx = aw;
      if (cy > ah) cy = ah;
      if (fx > aw) fx = aw;
      if (fy > ah) fy = ah;
      if (cx < fx) cx = fx;
      if (cy < fy) cy = fy;
      rect_in.x0 = 13'(fx);
      rect_in.y0 = 13'(fy);
      rect_in.x1 = 13'(cx);
      rect_in.y1 = 13'(cy);
   end

   assign done  = v2_ff;
   assign under = under_ff;
   assign rect  = rect_ff;
endmodule

// ----- hw/rtl/rfab_fbuf.sv -----
// framebuffer with read-modify-write blend pipeline on a registered read
module rfab_fbuf #(
   parameter int FB_WIDTH  = rfab_pkg::FbWidthDefault,
   parameter int FB_HEIGHT = rfab_pkg::FbHeightDefault,
   localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [31:0]         rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  rfab_pkg::paint_type wr_paint
);
   logic [31:0] mem [FB_WIDTH*FB_HEIGHT];
   logic [31:0] rd_data_ff;
   logic [31:0] wdata;
   logic [7:0]  ia;

   always_comb begin
      ia = 8'd255 - wr_paint.alpha;
      if (wr_paint.clear || wr_paint.alpha == 8'd255) begin
         wdata = {wr_paint.alpha, wr_paint.red, wr_paint.green, wr_paint.blue};
      end else begin
         wdata = {8'hFF,
            rfab_pkg::div255(16'(wr_paint.red * wr_paint.alpha)
                             + 16'(rd_data_ff[23:16] * ia)),
            rfab_pkg::div255(16'(wr_paint.green * wr_paint.alpha)
                             + 16'(rd_data_ff[15:8] * ia)),
            rfab_pkg::div255(16'(wr_paint.blue * wr_paint.alpha)
                             + 16'(rd_data_ff[7:0] * ia))};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wdata;
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/rect_fill_alpha_blend_engine.sv -----
// channel  | ports                                   | direction
// req      | req_valid/req_ready + operation fields  | in
// rsp      | rsp_valid/rsp_ready + rsp_read_data     | out
// csr      | psel penable pwrite paddr pwdata prdata | in/out (apb)
//
// clear: a read then a write of the framebuffer per active pixel
// fill: transform setup, then a read and a write per covered pixel; outline is four fills
// read: transform then registered read; cost of every item is set by the framebuffer
// synchronous active-high reset; framebuffer is not cleared
// a finished word waits in the rsp register; the next word is taken meanwhile
// and holds in the resp state while the previous word is still waiting
module rect_fill_alpha_blend_engine #(
   parameter int FB_WIDTH  = rfab_pkg::FbWidthDefault,
   parameter int FB_HEIGHT = rfab_pkg::FbHeightDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_operation,
   input  logic [15:0]  req_pos_x,
   input  logic [15:0]  req_pos_y,
   input  logic [15:0]  req_size_w,
   input  logic [15:0]  req_size_h,
   input  logic [7:0]   req_red,
   input  logic [7:0]   req_green,
   input  logic [7:0]   req_blue,
   input  logic [7:0]   req_alpha,
   input  logic         req_use_camera,
   input  logic [7:0]   req_thickness,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_read_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_XF_START, ST_XF_WAIT, ST_PIX_RD, ST_PIX_WR,
      ST_NEXT_PART, ST_READ_MEM, ST_READ_OUT, ST_RESP
   } state_type;

   state_type state_ff;

   // config registers
   logic [8:0]  act_w_ff, act_h_ff;
   logic [15:0] cam_x_ff, cam_y_ff, zoom_ff;
   logic [12:0] eff_w, eff_h;

   // operation latch
   rfab_pkg::op_type op_ff;
   logic signed [17:0] px_ff, py_ff, sw_ff, sh_ff, bd_ff;
   logic [7:0]  r_ff, g_ff, b_ff, a_ff;
   logic        cam_ff;
   logic [1:0]  part_ff;

   // walk
   rfab_pkg::rect_type rect_ff;
   logic [12:0] x_ff, y_ff;
   logic [AW-1:0] addr_ff, row_ff;

   // result of the item in work, copied to the rsp register when it is free
   logic [31:0] res_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_load;

   // transform stage
   logic        xf_start, xf_done, xf_under;
   logic signed [17:0] xf_px, xf_py, xf_sw, xf_sh;
   rfab_pkg::rect_type xf_rect;

   logic                fb_rd_en, fb_wr_en;
   logic [AW-1:0]       fb_rd_addr;
   logic [31:0]         fb_rd_data;
   rfab_pkg::paint_type paint;
   logic                csr_wr;
   logic [2:0]          csr_idx;

   assign eff_w = (act_w_ff == 9'd0) ? 13'd1 :
                  (13'(act_w_ff) > 13'(FB_WIDTH)) ? 13'(FB_WIDTH) : 13'(act_w_ff);
   assign eff_h = (act_h_ff == 9'd0) ? 13'd1 :
                  (13'(act_h_ff) > 13'(FB_HEIGHT)) ? 13'(FB_HEIGHT) : 13'(act_h_ff);

   // the four outline parts: top, bottom, left, right
   always_comb begin
      xf_px = px_ff;
      xf_py = py_ff;
      xf_sw = sw_ff;
      xf_sh = sh_ff;
      if (op_ff == rfab_pkg::OP_OUTLINE) begin
         case (part_ff)
            2'd0: xf_sh = bd_ff;
            2'd1: begin
               xf_py = py_ff + sh_ff - bd_ff;
               xf_sh = bd_ff;
            end
            2'd2: xf_sw = bd_ff;
            default: begin
               xf_px = px_ff + sw_ff - bd_ff;
               xf_sw = bd_ff;
            end
         endcase
      end
   end

   assign xf_start = (state_ff == ST_XF_START);

   rfab_xform u_xform (
      .clock  (clock),
      .start  (xf_start),
      .px     (xf_px),
      .py     (xf_py),
      .sw     (xf_sw),
      .sh     (xf_sh),
      .cam_on (cam_ff),
      .cam_x  (cam_x_ff),
      .cam_y  (cam_y_ff),
      .zoom   (zoom_ff),
      .act_w  (eff_w),
      .act_h  (eff_h),
      .done   (xf_done),
      .under  (xf_under),
      .rect   (xf_rect)
   );

   assign fb_rd_en   = (state_ff == ST_PIX_RD) || (state_ff == ST_READ_MEM);
   assign fb_rd_addr = addr_ff;
   assign fb_wr_en   = (state_ff == ST_PIX_WR) &&
                       (op_ff == rfab_pkg::OP_CLEAR || a_ff != 8'd0);
   assign paint.clear = (op_ff == rfab_pkg::OP_CLEAR);
   assign paint.red   = r_ff;
   assign paint.green = g_ff;
   assign paint.blue  = b_ff;
   assign paint.alpha = a_ff;

   rfab_fbuf #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_fbuf (
      .clock    (clock),
      .rd_en    (fb_rd_en),
      .rd_addr  (fb_rd_addr),
      .rd_data  (fb_rd_data),
      .wr_en    (fb_wr_en),
      .wr_addr  (addr_ff),
      .wr_paint (paint)
   );

   // apb
   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;
   always_comb begin
      unique case (csr_idx)
         rfab_pkg::REG_ACTIVE_WIDTH:  prdata = {23'd0, act_w_ff};
         rfab_pkg::REG_ACTIVE_HEIGHT: prdata = {23'd0, act_h_ff};
         rfab_pkg::REG_CAMERA_X:      prdata = {16'd0, cam_x_ff};
         rfab_pkg::REG_CAMERA_Y:      prdata = {16'd0, cam_y_ff};
         rfab_pkg::REG_CAMERA_ZOOM:   prdata = {16'd0, zoom_ff};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_w_ff <= 9'd256;
         act_h_ff <= 9'd256;
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         zoom_ff  <= 16'd256;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rfab_pkg::REG_ACTIVE_WIDTH:  act_w_ff <= pwdata[8:0];
            rfab_pkg::REG_ACTIVE_HEIGHT: act_h_ff <= pwdata[8:0];
            rfab_pkg::REG_CAMERA_X:      cam_x_ff <= pwdata[15:0];
            rfab_pkg::REG_CAMERA_Y:      cam_y_ff <= pwdata[15:0];
            rfab_pkg::REG_CAMERA_ZOOM:   zoom_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // rsp register is free when empty or being taken this cycle
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               op_ff   <= rfab_pkg::op_type'(req_operation);
               px_ff   <= 18'(signed'(req_pos_x));
               py_ff   <= 18'(signed'(req_pos_y));
               sw_ff   <= signed'({2'b0, req_size_w});
               sh_ff   <= signed'({2'b0, req_size_h});
               bd_ff   <= signed'({6'd0, (req_thickness == 8'd0) ? 8'd1 : req_thickness,
                                   4'd0});
               r_ff    <= req_red;
               g_ff    <= req_green;
               b_ff    <= req_blue;
               a_ff    <= req_alpha;
               cam_ff  <= req_use_camera;
               part_ff <= 2'd0;
               if (rfab_pkg::op_type'(req_operation) == rfab_pkg::OP_CLEAR) begin
                  rect_ff <= '{x0: 13'd0, y0: 13'd0, x1: eff_w, y1: eff_h};
                  x_ff    <= '0;
                  y_ff    <= '0;
                  addr_ff <= '0;
                  row_ff  <= '0;
                  state_ff <= ST_PIX_RD;
               end else begin
                  state_ff <= ST_XF_START;
               end
            end
            ST_XF_START: state_ff <= ST_XF_WAIT;
            ST_XF_WAIT: if (xf_done) begin
               rect_ff <= xf_rect;
               x_ff    <= xf_rect.x0;
               y_ff    <= xf_rect.y0;
               addr_ff <= AW'(32'(xf_rect.y0) * 32'(eff_w) + 32'(xf_rect.x0));
               row_ff  <= AW'(32'(xf_rect.y0) * 32'(eff_w));
               if (op_ff == rfab_pkg::OP_READ) begin
                  // a read point outside the active area answers zero
                  if (!xf_under && xf_rect.x0 < eff_w && xf_rect.y0 < eff_h) begin
                     state_ff <= ST_READ_MEM;
                  end else begin
                     res_ff   <= '0;
                     state_ff <= ST_RESP;
                  end
               end else if (xf_rect.x0 == xf_rect.x1 || xf_rect.y0 == xf_rect.y1) begin
                  state_ff <= ST_NEXT_PART;
               end else begin
                  state_ff <= ST_PIX_RD;
               end
            end
            ST_PIX_RD: state_ff <= ST_PIX_WR;
            ST_PIX_WR: begin
               if (x_ff + 13'd1 < rect_ff.x1) begin
                  x_ff     <= x_ff + 13'd1;
                  addr_ff  <= addr_ff + AW'(1);
                  state_ff <= ST_PIX_RD;
               end else if (y_ff + 13'd1 < rect_ff.y1) begin
                  y_ff     <= y_ff + 13'd1;
                  x_ff     <= rect_ff.x0;
                  row_ff   <= row_ff + AW'(eff_w);
                  addr_ff  <= row_ff + AW'(eff_w) + AW'(rect_ff.x0);
                  state_ff <= ST_PIX_RD;
               end else if (op_ff == rfab_pkg::OP_CLEAR) begin
                  res_ff   <= '0;
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_NEXT_PART;
               end
            end
            ST_NEXT_PART: begin
               if (op_ff == rfab_pkg::OP_OUTLINE && part_ff != 2'd3) begin
                  part_ff  <= part_ff + 2'd1;
                  state_ff <= ST_XF_START;
               end else begin
                  res_ff   <= '0;
                  state_ff <= ST_RESP;
               end
            end
            ST_READ_MEM: state_ff <= ST_READ_OUT;
            ST_READ_OUT: begin
               res_ff   <= fb_rd_data;
               state_ff <= ST_RESP;
            end
            ST_RESP: if (rsp_load) begin
               rsp_data_ff <= res_ff;
               state_ff    <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
